[hdl/bgmp_pkg.sv]
// Package for the body group mass properties block: payload structs,
// sequencer states and sizing defaults. No dependencies.
package bgmp_pkg;

  localparam int DEF_MAX_BODIES = 16;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic        [31:0] body_mass;
    logic               last_body;
  } body_t;

  typedef struct packed {
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_vel_x;
    logic signed [31:0] centre_vel_y;
    logic        [62:0] moment_of_inertia;
    logic signed [63:0] spin_momentum;
    logic        [4:0]  bodies_used;
    logic               bodies_dropped;
  } result_t;

  // One stored body
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic        [31:0] mass;
  } entry_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SUM,
    S_DIV,
    S_CROSS,
    S_SPIN,
    S_FIN
  } state_t;

  // Centre index of each divider run
  localparam logic [1:0] CEN_X  = 2'd0;
  localparam logic [1:0] CEN_Y  = 2'd1;
  localparam logic [1:0] CEN_VX = 2'd2;
  localparam logic [1:0] CEN_VY = 2'd3;

endpackage

[hdl/body_group_mass_properties.sv]
// Body group mass properties: body store memory, two passes over it and a
// shared serial divider. Depends on bgmp_pkg.
//
// Bodies load one per cycle, when not stalled, into a body memory (MAX_BODIES
// entries, one synchronous read port). The transfer that carries last_body
// closes the group; the block then stalls its input while it makes a first
// pass over the stored bodies to form the mass-weighted sums, runs a
// one-bit-per-cycle divider four times for the centres (skipped when the
// total mass is zero), and makes a second pass for moment of inertia and
// spin momentum. One result then goes to the output register, and loading of
// the next group resumes while that result waits to be taken. Bodies beyond
// MAX_BODIES are dropped and reported in bodies_dropped; bodies_used is the
// stored count taken modulo 32.
module body_group_mass_properties #(
  parameter int MAX_BODIES = bgmp_pkg::DEF_MAX_BODIES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             body_valid,
  output logic             body_stall,
  input  bgmp_pkg::body_t   body,
  output logic             result_valid,
  input  logic             result_stall,
  output bgmp_pkg::result_t result
);
  import bgmp_pkg::*;

  localparam int CW   = $clog2(MAX_BODIES + 1);
  localparam int IW   = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int SUMW = 65 + CW;
  localparam int TOTW = 32 + CW;
  localparam int DCW  = $clog2(SUMW + 1);
  localparam int INW  = 98 + CW;
  localparam int SPW  = 99 + CW;

  state_t state, state_next;

  logic [CW-1:0] count;
  logic          overflow;

  entry_t mem [MAX_BODIES];
  entry_t rd_q;
  logic [CW-1:0] rd_idx;
  logic          v1;
  logic          issue;
  logic          accept;

  // first pass
  logic signed [64:0] pr_x, pr_y, pr_vx, pr_vy;
  logic [31:0]        pr_m;
  logic               pv;
  logic signed [SUMW-1:0] sum_x, sum_y, sum_vx, sum_vy;
  logic [TOTW-1:0]        total;

  // divider
  logic [1:0]       div_sel;
  logic             div_busy;
  logic [SUMW-1:0]  dvd, quo;
  logic [TOTW-1:0]  rem;
  logic [DCW-1:0]   div_cnt;
  logic             div_neg;
  logic [TOTW:0]    rem_sh;
  logic             div_ge;
  logic signed [SUMW-1:0] div_src;
  logic signed [31:0] quo_clamp;
  logic signed [31:0] cen [4];

  // second pass
  logic signed [63:0] cr_p, cr_q;
  logic signed [32:0] dx, dy;
  logic signed [65:0] dx_sq, dy_sq;
  logic [63:0]        sq_x, sq_y;
  logic signed [63:0] ca, cb;
  logic [31:0]        m2, m3;
  logic               sv2, sv3, sv4;
  logic signed [65:0] s_val;
  logic [65:0]        w3, smag3;
  logic               sneg3, sneg4;
  logic [64:0]        pw_lo, pw_hi, ps_lo, ps_hi;
  logic [INW-1:0]     inert;
  logic signed [SPW-1:0] spin, spin_term;

  logic        pass1_done, pass2_done;
  logic [62:0] moi_out;
  logic [63:0] spin_out;
  logic [CW+4:0] count_ext;

  assign accept     = body_valid && !body_stall;
  assign body_stall = (state != S_LOAD);
  assign issue      = (state == S_SUM || state == S_SPIN) && (rd_idx < count);
  assign pass1_done = (rd_idx == count) && !v1 && !pv;
  assign pass2_done = (rd_idx == count) && !v1 && !sv2 && !sv3 && !sv4;

  // divider step and clamp of the finished quotient
  always_comb begin
    case (div_sel)
      CEN_X:   div_src = sum_x;
      CEN_Y:   div_src = sum_y;
      CEN_VX:  div_src = sum_vx;
      default: div_src = sum_vy;
    endcase
    rem_sh = {rem, dvd[SUMW-1]};
    div_ge = rem_sh >= {1'b0, total};
    if (div_neg) begin
      if ((|quo[SUMW-1:32]) || quo[31:0] > 32'h8000_0000) quo_clamp = 32'sh8000_0000;
      else quo_clamp = -$signed(quo[31:0]);
    end else begin
      if ((|quo[SUMW-1:32]) || quo[31]) quo_clamp = 32'sh7fff_ffff;
      else quo_clamp = $signed(quo[31:0]);
    end
  end

  // second pass arithmetic
  always_comb begin
    dx    = {rd_q.pos_x[31], rd_q.pos_x} - {cen[CEN_X][31], cen[CEN_X]};
    dy    = {rd_q.pos_y[31], rd_q.pos_y} - {cen[CEN_Y][31], cen[CEN_Y]};
    dx_sq = dx * dx;
    dy_sq = dy * dy;
    s_val = {{2{ca[63]}}, ca} - {{2{cb[63]}}, cb}
          - {{2{cr_p[63]}}, cr_p} + {{2{cr_q[63]}}, cr_q};
    spin_term = SPW'(ps_lo) + (SPW'(ps_hi) << 33);
  end

  // final scaling and saturation
  always_comb begin
    if (|inert[INW-1:79]) moi_out = 63'h7fff_ffff_ffff_ffff;
    else moi_out = inert[78:16];
    if ((&spin[SPW-1:79]) || !(|spin[SPW-1:79])) spin_out = spin[79:16];
    else if (spin[SPW-1]) spin_out = 64'h8000_0000_0000_0000;
    else spin_out = 64'h7fff_ffff_ffff_ffff;
    count_ext = {5'b0, count};
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:  if (accept && body.last_body) state_next = S_SUM;
      S_SUM:   if (pass1_done) state_next = S_DIV;
      S_DIV: begin
        if (total == '0) state_next = S_CROSS;
        else if (div_busy && div_cnt == '0 && div_sel == CEN_VY) state_next = S_CROSS;
      end
      S_CROSS: state_next = S_SPIN;
      S_SPIN:  if (pass2_done) state_next = S_FIN;
      S_FIN:   if (!result_valid || !result_stall) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else state <= state_next;
  end

  // body memory: write on load, read one entry a cycle during the passes
  always_ff @(posedge clk) begin
    if (accept && count < CW'(MAX_BODIES)) begin
      mem[count[IW-1:0]] <= '{pos_x: body.position_x, pos_y: body.position_y,
                             vel_x: body.velocity_x, vel_y: body.velocity_y,
                             mass: body.body_mass};
    end
    rd_q <= mem[rd_idx[IW-1:0]];
  end

  // datapath and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      overflow     <= 1'b0;
      rd_idx       <= '0;
      v1           <= 1'b0;
      pv           <= 1'b0;
      sv2          <= 1'b0;
      sv3          <= 1'b0;
      sv4          <= 1'b0;
      div_busy     <= 1'b0;
      div_sel      <= CEN_X;
      result_valid <= 1'b0;
    end else begin
      v1  <= issue;
      pv  <= v1 && state == S_SUM;
      sv2 <= v1 && state == S_SPIN;
      sv3 <= sv2;
      sv4 <= sv3;
      if (issue) rd_idx <= rd_idx + 1'b1;
      if (result_valid && !result_stall) result_valid <= 1'b0;

      case (state)
        S_LOAD: begin
          if (accept) begin
            if (count < CW'(MAX_BODIES)) count <= count + 1'b1;
            else overflow <= 1'b1;
            if (body.last_body) begin
              rd_idx   <= '0;
              div_sel  <= CEN_X;
              div_busy <= 1'b0;
            end
          end
        end
        S_SUM: if (pass1_done) rd_idx <= '0;
        S_DIV: begin
          if (!div_busy) begin
            div_busy <= 1'b1;
            div_neg  <= div_src[SUMW-1];
            dvd      <= div_src[SUMW-1] ? -div_src : div_src;
            quo      <= '0;
            rem      <= '0;
            div_cnt  <= DCW'(SUMW);
          end else if (div_cnt != '0) begin
            rem     <= div_ge ? TOTW'(rem_sh - {1'b0, total}) : rem_sh[TOTW-1:0];
            quo     <= {quo[SUMW-2:0], div_ge};
            dvd     <= dvd << 1;
            div_cnt <= div_cnt - 1'b1;
          end else begin
            div_busy <= 1'b0;
            div_sel  <= div_sel + 1'b1;
          end
        end
        S_FIN: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            count        <= '0;
            overflow     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // arithmetic registers (no reset needed)
  always_ff @(posedge clk) begin
    // clear the sums when a group closes
    if (accept && body.last_body) begin
      sum_x  <= '0;
      sum_y  <= '0;
      sum_vx <= '0;
      sum_vy <= '0;
      total  <= '0;
      inert  <= '0;
      spin   <= '0;
      for (int k = 0; k < 4; k++) cen[k] <= '0;
    end

    // first pass: weight each entry by its mass, then accumulate
    pr_x  <= $signed({1'b0, rd_q.mass}) * rd_q.pos_x;
    pr_y  <= $signed({1'b0, rd_q.mass}) * rd_q.pos_y;
    pr_vx <= $signed({1'b0, rd_q.mass}) * rd_q.vel_x;
    pr_vy <= $signed({1'b0, rd_q.mass}) * rd_q.vel_y;
    pr_m  <= rd_q.mass;
    if (pv) begin
      sum_x  <= sum_x + SUMW'(pr_x);
      sum_y  <= sum_y + SUMW'(pr_y);
      sum_vx <= sum_vx + SUMW'(pr_vx);
      sum_vy <= sum_vy + SUMW'(pr_vy);
      total  <= total + TOTW'(pr_m);
    end

    // store a finished centre
    if (state == S_DIV && div_busy && div_cnt == '0) cen[div_sel] <= quo_clamp;

    // orbital cross term of the centre
    if (state == S_CROSS) begin
      cr_p <= cen[CEN_X] * cen[CEN_VY];
      cr_q <= cen[CEN_Y] * cen[CEN_VX];
    end

    // second pass: squares and cross products, then mass products, then sum
    sq_x  <= dx_sq[63:0];
    sq_y  <= dy_sq[63:0];
    ca    <= rd_q.pos_x * rd_q.vel_y;
    cb    <= rd_q.pos_y * rd_q.vel_x;
    m2    <= rd_q.mass;
    w3    <= {2'b0, sq_x} + {2'b0, sq_y};
    smag3 <= s_val[65] ? 66'(-s_val) : 66'(s_val);
    sneg3 <= s_val[65];
    m3    <= m2;
    pw_lo <= m3 * w3[32:0];
    pw_hi <= m3 * w3[65:33];
    ps_lo <= m3 * smag3[32:0];
    ps_hi <= m3 * smag3[65:33];
    sneg4 <= sneg3;
    if (sv4) begin
      inert <= inert + INW'(pw_lo) + (INW'(pw_hi) << 33);
      spin  <= sneg4 ? spin - spin_term : spin + spin_term;
    end

    // result register
    if (state == S_FIN && (!result_valid || !result_stall)) begin
      result.centre_x          <= cen[CEN_X];
      result.centre_y          <= cen[CEN_Y];
      result.centre_vel_x      <= cen[CEN_VX];
      result.centre_vel_y      <= cen[CEN_VY];
      result.moment_of_inertia <= moi_out;
      result.spin_momentum     <= spin_out;
      result.bodies_used       <= count_ext[4:0];
      result.bodies_dropped    <= overflow;
    end
  end

endmodule

[hdl/bgmp_checker.sv]
// Port checker for the body group mass properties block and its bind.
// Depends on bgmp_pkg.
module bgmp_checker #(
  parameter int MAX_BODIES = bgmp_pkg::DEF_MAX_BODIES
) (
  input logic              clk,
  input logic              rst,
  input logic              body_valid,
  input logic              body_stall,
  input bgmp_pkg::body_t   body,
  input logic              result_valid,
  input logic              result_stall,
  input bgmp_pkg::result_t result
);
  import bgmp_pkg::*;

  // a closing body starts the computation, so input must stall next
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    body_valid && !body_stall && body.last_body |=> body_stall)
    else $error("input not stalled after closing body");

  // the reported count never exceeds the store size
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (MAX_BODIES > 31) || (result.bodies_used <= MAX_BODIES))
    else $error("bodies_used above store size");

  // hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind body_group_mass_properties bgmp_checker #(.MAX_BODIES(MAX_BODIES)) u_bgmp_checker (
  .clk(clk), .rst(rst), .body_valid(body_valid), .body_stall(body_stall), .body(body),
  .result_valid(result_valid), .result_stall(result_stall), .result(result)
);
